// File: rtl/itda_pkg.sv
// Shared constants and sizing functions for the integer to decimal ASCII unit.
package itda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int BITS_PER_STAGE  = 4;

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_NINE  = 6'd57;

  // decimal digits of 2^(w-1), the largest magnitude a w-bit signed value has
  function automatic int num_digits(input int w);
    return ((w - 1) * 30103) / 100000 + 1;
  endfunction

  function automatic int num_stages(input int w);
    return (w + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  endfunction

endpackage

// File: rtl/itda_prep.sv
// Input stage: sign split and two's complement magnitude, zero padded for the BCD pipe.
module itda_prep #(
  parameter int VW = itda_pkg::VALUE_WIDTH_DEF,
  parameter int PW = itda_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [VW-1:0] value_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic          neg_o,
  output logic [PW-1:0] mag_o
);
  import itda_pkg::*;

  logic          valid_r;
  logic          neg_r;
  logic [PW-1:0] mag_r;
  logic          en;
  logic [VW-1:0] mag_raw;

  assign en      = !valid_r || ready_i;
  assign ready_o = en;
  // most negative value negates to 2^(VW-1), which still fits unsigned
  assign mag_raw = value_i[VW-1] ? (~value_i + 1'b1) : value_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      neg_r <= value_i[VW-1];
      mag_r <= PW'(mag_raw);
    end
  end

  assign valid_o = valid_r;
  assign neg_o   = neg_r;
  assign mag_o   = mag_r;

endmodule

// File: rtl/itda_dabble_stage.sv
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
module itda_dabble_stage #(
  parameter int PW = itda_pkg::VALUE_WIDTH_DEF,
  parameter int ND = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic            neg_i,
  input  logic [PW-1:0]   bin_i,
  input  logic [ND*4-1:0] bcd_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            neg_o,
  output logic [PW-1:0]   bin_o,
  output logic [ND*4-1:0] bcd_o
);
  import itda_pkg::*;

  logic            valid_r;
  logic            neg_r;
  logic [PW-1:0]   bin_r;
  logic [ND*4-1:0] bcd_r;
  logic            en;
  logic [PW-1:0]   bin_v;
  logic [ND*4-1:0] bcd_v;

  assign en      = !valid_r || ready_i;
  assign ready_o = en;

  always_comb begin
    bin_v = bin_i;
    bcd_v = bcd_i;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_v[d*4 +: 4] >= 4'd5) begin
          bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v, bin_v} << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      neg_r <= neg_i;
      bin_r <= bin_v;
      bcd_r <= bcd_v;
    end
  end

  assign valid_o = valid_r;
  assign neg_o   = neg_r;
  assign bin_o   = bin_r;
  assign bcd_o   = bcd_r;

endmodule

// File: rtl/itda_serial.sv
// Character serializer: leading zero skip, sign, then digits into the output register.
module itda_serial #(
  parameter int ND = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic            neg_i,
  input  logic [ND*4-1:0] bcd_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      out_char,
  output logic            out_last
);
  import itda_pkg::*;

  localparam int IW = $clog2(ND);

  logic            busy_r, busy_nxt;
  logic            neg_r, neg_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [ND*4-1:0] bcd_r;
  logic            out_valid_r, out_valid_nxt;
  logic [5:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;
  logic            take_out;
  logic            last_step;
  logic            load;
  logic [IW-1:0]   lead;

  assign take_out  = !out_valid_r || out_ready;
  assign last_step = busy_r && !neg_r && (idx_r == '0) && take_out;
  assign ready_o   = !busy_r || last_step;
  assign load      = valid_i && ready_o;

  // index of the most significant nonzero digit, zero for a zero value
  always_comb begin
    lead = '0;
    for (int i = 0; i < ND; i++) begin
      if (bcd_i[i*4 +: 4] != 4'd0) begin
        lead = IW'(i);
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (take_out) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        if (neg_r) begin
          out_char_nxt = CHAR_MINUS;
          out_last_nxt = 1'b0;
          neg_nxt      = 1'b0;
        end else begin
          out_char_nxt = CHAR_ZERO + {2'b00, bcd_r[idx_r*4 +: 4]};
          out_last_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            busy_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      neg_nxt  = neg_i;
      idx_nxt  = lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (load) begin
      bcd_r <= bcd_i;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (int'(idx_r) < ND))
    else $error("digit index beyond digit count");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS ||
                     (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_NINE)))
    else $error("output character is neither sign nor digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last character");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && neg_i) |=> (busy_r && neg_r))
    else $error("negative item lost its pending sign");

endmodule

// File: rtl/signed_int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII text: prep stage, BCD pipeline and serializer.
//
// Input channel in_*: one beat per signed integer, value in in_tdata (two's
// complement, low VALUE_WIDTH bits used, top bit is the sign).
// Output channel out_*: one beat per character, most significant first.
// out_tdata[5:0] holds the ASCII code ('-' or '0'..'9'), out_tlast marks the
// final character of one value's text. Leading zeros are dropped, zero gives
// a single '0', the most negative value converts exactly.
// Path: the prep register takes the input beat, each BCD stage does 4 bits of
// shift-and-add-3, then the serializer loads and fills the output register.
// Throughput: one character per cycle from the output register while
// out_tready is high, so an item occupies 1 to ND+1 characters (sign plus
// digit count); the serializer sets this. Up to num_stages + 1 items sit in
// the pipeline behind it.
// Reset (rst_n low, synchronous) empties every stage and the output register.
// When the receiver holds out_tready low the output beat holds, the pipeline
// fills and in_tready drops; nothing is lost or repeated.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] in_tdata,   // value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,  // character, 2'b0 pad
  output logic                                 out_tlast   // last_char
);
  import itda_pkg::*;

  localparam int NSTG = num_stages(VALUE_WIDTH);
  localparam int PW   = NSTG * BITS_PER_STAGE;
  localparam int ND   = num_digits(VALUE_WIDTH);

  logic            st_valid [NSTG+1];
  logic            st_ready [NSTG+1];
  logic            st_neg   [NSTG+1];
  logic [PW-1:0]   st_bin   [NSTG+1];
  logic [ND*4-1:0] st_bcd   [NSTG+1];
  logic [5:0]      out_char;

  itda_prep #(
    .VW (VALUE_WIDTH),
    .PW (PW)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .value_i (in_tdata[VALUE_WIDTH-1:0]),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .neg_o   (st_neg[0]),
    .mag_o   (st_bin[0])
  );

  assign st_bcd[0] = '0;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    itda_dabble_stage #(
      .PW (PW),
      .ND (ND)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (st_valid[s]),
      .ready_o (st_ready[s]),
      .neg_i   (st_neg[s]),
      .bin_i   (st_bin[s]),
      .bcd_i   (st_bcd[s]),
      .valid_o (st_valid[s+1]),
      .ready_i (st_ready[s+1]),
      .neg_o   (st_neg[s+1]),
      .bin_o   (st_bin[s+1]),
      .bcd_o   (st_bcd[s+1])
    );
  end

  itda_serial #(
    .ND (ND)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (st_valid[NSTG]),
    .ready_o   (st_ready[NSTG]),
    .neg_i     (st_neg[NSTG]),
    .bcd_i     (st_bcd[NSTG]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_char};

endmodule
